>>> hdl/dat_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dat_pkg
// Shared types, constants and codes of the delivery acknowledgement tracker.
// ============================================================================
package dat_pkg;

   // Field widths
   localparam int FuncWidth  = 3;
   localparam int SeqWidth   = 32;
   localparam int CountWidth = 16;
   localparam int TimeWidth  = 32;

   // Pending delivery queue
   localparam int PendingDepth = 64;
   localparam int PtrWidth     = $clog2(PendingDepth);
   localparam int FillWidth    = $clog2(PendingDepth + 1);
   localparam int EntryWidth   = SeqWidth + TimeWidth;

   // Most results that one walk may produce
   localparam int ResultLimit      = 64;
   localparam int ResultCountWidth = $clog2(ResultLimit + 1);

   // Command queue between front and back
   localparam int CmdQueueDepth = 2;
   localparam int CmdPtrWidth   = $clog2(CmdQueueDepth);
   localparam int CmdCountWidth = $clog2(CmdQueueDepth + 1);

   // Register port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic CsrIndexAckTimeout = 1'b0;
   localparam logic [SeqWidth-1:0] AckTimeoutReset = 32'd1000;

   localparam logic [CountWidth-1:0] AckCountMax = '1;

   // Input function codes
   localparam logic [FuncWidth-1:0] FUNC_SEND        = 3'd0;
   localparam logic [FuncWidth-1:0] FUNC_RECEIVE     = 3'd1;
   localparam logic [FuncWidth-1:0] FUNC_BUILD_ACK   = 3'd2;
   localparam logic [FuncWidth-1:0] FUNC_PROCESS_ACK = 3'd3;
   localparam logic [FuncWidth-1:0] FUNC_TIMEOUT     = 3'd4;
   localparam logic [FuncWidth-1:0] FUNC_CLEAR       = 3'd5;

   typedef enum logic [2:0] {
      OP_SEND,
      OP_RECEIVE,
      OP_BUILD_ACK,
      OP_PROCESS_ACK,
      OP_TIMEOUT,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      KIND_SENT     = 3'd0,
      KIND_ACCEPTED = 3'd1,
      KIND_REJECTED = 3'd2,
      KIND_ACK_REC  = 3'd3,
      KIND_SUCCESS  = 3'd4,
      KIND_FAILURE  = 3'd5,
      KIND_DONE     = 3'd6,
      KIND_FULL     = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic [FuncWidth-1:0]  func;
      logic [SeqWidth-1:0]   seq_number;
      logic [CountWidth-1:0] ack_count;
      logic [TimeWidth-1:0]  now;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [SeqWidth-1:0]   seq_out;
      logic [CountWidth-1:0] count_out;
      logic                  acks_pending;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic [SeqWidth-1:0]   seq_number;
      logic [CountWidth-1:0] ack_count;
      logic [TimeWidth-1:0]  now;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

>>> hdl/dat_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// dat_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dat_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dat_front.sv
`timescale 1ns / 1ps
// ============================================================================
// dat_front
// Accepts input items, decodes the function code and queues the command.
// ============================================================================
module dat_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dat_pkg::req_type      req_payload,
   output dat_pkg::cmd_chan_type cmd_chan,
   input  logic                  cmd_take
);

   dat_pkg::cmd_type                  q_ff [dat_pkg::CmdQueueDepth];
   logic [dat_pkg::CmdPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dat_pkg::CmdPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dat_pkg::CmdCountWidth-1:0] count_ff, count_in;
   dat_pkg::cmd_type                  decoded;
   logic                              push;
   logic                              pop;

   always_comb begin
      decoded.seq_number = req_payload.seq_number;
      decoded.ack_count  = req_payload.ack_count;
      decoded.now        = req_payload.now;
      unique case (req_payload.func)
         dat_pkg::FUNC_SEND:        decoded.op = dat_pkg::OP_SEND;
         dat_pkg::FUNC_RECEIVE:     decoded.op = dat_pkg::OP_RECEIVE;
         dat_pkg::FUNC_BUILD_ACK:   decoded.op = dat_pkg::OP_BUILD_ACK;
         dat_pkg::FUNC_PROCESS_ACK: decoded.op = dat_pkg::OP_PROCESS_ACK;
         dat_pkg::FUNC_TIMEOUT:     decoded.op = dat_pkg::OP_TIMEOUT;
         dat_pkg::FUNC_CLEAR:       decoded.op = dat_pkg::OP_CLEAR;
         default:                   decoded.op = dat_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == dat_pkg::CmdCountWidth'(dat_pkg::CmdQueueDepth));
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_take && (count_ff != '0);

   assign cmd_chan.valid = (count_ff != '0);
   assign cmd_chan.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == dat_pkg::CmdPtrWidth'(dat_pkg::CmdQueueDepth - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == dat_pkg::CmdPtrWidth'(dat_pkg::CmdQueueDepth - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> hdl/dat_back.sv
`timescale 1ns / 1ps
// ============================================================================
// dat_back
// Executes commands: counters, ack record, pending queue walks and results.
// ============================================================================
module dat_back (
   input  logic                          clock,
   input  logic                          reset,
   input  dat_pkg::cmd_chan_type         cmd_chan,
   output logic                          cmd_take,
   input  logic [dat_pkg::SeqWidth-1:0]  ack_timeout,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dat_pkg::rsp_type              rsp_payload
);

   localparam int SumWidth = dat_pkg::FillWidth + 1;

   dat_pkg::back_state_type state_ff, state_in;

   logic [dat_pkg::SeqWidth-1:0]   next_out_seq_ff, next_out_seq_in;
   logic [dat_pkg::SeqWidth-1:0]   next_expected_seq_ff, next_expected_seq_in;
   logic [dat_pkg::SeqWidth-1:0]   ack_first_ff, ack_first_in;
   logic [dat_pkg::CountWidth-1:0] ack_pending_count_ff, ack_pending_count_in;
   logic [dat_pkg::PtrWidth-1:0]   head_ff, head_in;
   logic [dat_pkg::FillWidth-1:0]  fill_ff, fill_in;

   logic                                   walk_ack_ff, walk_ack_in;
   logic [dat_pkg::SeqWidth-1:0]           nxt_ff, nxt_in;
   logic [dat_pkg::SeqWidth-1:0]           end_ff, end_in;
   logic [dat_pkg::TimeWidth-1:0]          limit_ff, limit_in;
   logic [dat_pkg::ResultCountWidth-1:0]   n_ff, n_in;
   logic                                   hold_valid_ff, hold_valid_in;
   dat_pkg::kind_type                      hold_kind_ff, hold_kind_in;
   logic [dat_pkg::SeqWidth-1:0]           hold_seq_ff, hold_seq_in;

   logic             rsp_valid_ff, rsp_valid_in;
   dat_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic                            out_free;
   logic                            ram_wr_en;
   logic [dat_pkg::PtrWidth-1:0]    ram_wr_addr;
   logic [dat_pkg::EntryWidth-1:0]  ram_wr_data;
   logic                            ram_rd_en;
   logic [dat_pkg::EntryWidth-1:0]  ram_rd_data;
   logic [dat_pkg::SeqWidth-1:0]    entry_seq;
   logic [dat_pkg::TimeWidth-1:0]   entry_time;
   logic [SumWidth-1:0]             tail_sum;
   logic [dat_pkg::PtrWidth-1:0]    tail_pos;
   logic [dat_pkg::PtrWidth-1:0]    head_next;
   logic                            walk_go;
   logic                            ev_emit;
   logic                            ev_stop;
   dat_pkg::kind_type               ev_kind;
   logic [dat_pkg::CountWidth-1:0]  count_new;
   dat_pkg::cmd_type                cmd;

   dat_ram #(
      .Width (dat_pkg::EntryWidth),
      .Depth (dat_pkg::PendingDepth)
   ) u_pending (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign cmd        = cmd_chan.cmd;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign entry_seq  = ram_rd_data[dat_pkg::EntryWidth-1 -: dat_pkg::SeqWidth];
   assign entry_time = ram_rd_data[dat_pkg::TimeWidth-1:0];

   // Tail position: head plus fill, wrapped once
   assign tail_sum = SumWidth'(head_ff) + SumWidth'(fill_ff);
   assign tail_pos = (tail_sum >= SumWidth'(dat_pkg::PendingDepth)) ?
                     dat_pkg::PtrWidth'(tail_sum - SumWidth'(dat_pkg::PendingDepth)) :
                     dat_pkg::PtrWidth'(tail_sum);
   assign head_next = (head_ff == dat_pkg::PtrWidth'(dat_pkg::PendingDepth - 1)) ?
                      '0 : head_ff + 1'b1;

   assign ram_wr_addr = tail_pos;
   assign ram_wr_data = {next_out_seq_ff, cmd.now};

   // Another entry may be examined
   assign walk_go = (fill_ff != '0) &&
                    (n_ff < dat_pkg::ResultCountWidth'(dat_pkg::ResultLimit)) &&
                    (!walk_ack_ff || (nxt_ff < end_ff));

   // Decide on the entry at the head
   always_comb begin
      ev_emit = 1'b0;
      ev_stop = 1'b0;
      ev_kind = dat_pkg::KIND_SUCCESS;
      if (walk_ack_ff) begin
         if (entry_seq == nxt_ff) begin
            ev_emit = 1'b1;
         end else if (entry_seq < nxt_ff) begin
            ev_emit = 1'b1;
            ev_kind = dat_pkg::KIND_FAILURE;
         end else if (entry_seq < end_ff) begin
            ev_emit = 1'b1;
         end else begin
            ev_stop = 1'b1;
         end
      end else begin
         if (entry_time < limit_ff) begin
            ev_emit = 1'b1;
            ev_kind = dat_pkg::KIND_FAILURE;
         end else begin
            ev_stop = 1'b1;
         end
      end
   end

   assign count_new = (ack_pending_count_ff != dat_pkg::AckCountMax) ?
                      ack_pending_count_ff + 1'b1 : ack_pending_count_ff;

   always_comb begin
      state_in             = state_ff;
      next_out_seq_in      = next_out_seq_ff;
      next_expected_seq_in = next_expected_seq_ff;
      ack_first_in         = ack_first_ff;
      ack_pending_count_in = ack_pending_count_ff;
      head_in              = head_ff;
      fill_in              = fill_ff;
      walk_ack_in          = walk_ack_ff;
      nxt_in               = nxt_ff;
      end_in               = end_ff;
      limit_in             = limit_ff;
      n_in                 = n_ff;
      hold_valid_in        = hold_valid_ff;
      hold_kind_in         = hold_kind_ff;
      hold_seq_in          = hold_seq_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_payload_in       = rsp_payload_ff;
      cmd_take             = 1'b0;
      ram_wr_en            = 1'b0;
      ram_rd_en            = 1'b0;

      rsp_payload_in.count_out    = '0;
      rsp_payload_in.acks_pending = (ack_pending_count_ff != '0);
      rsp_payload_in.last         = 1'b1;

      unique case (state_ff)
         dat_pkg::ST_IDLE: begin
            if (cmd_chan.valid && out_free) begin
               cmd_take             = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_payload_in.kind    = dat_pkg::KIND_DONE;
               rsp_payload_in.seq_out = '0;
               unique case (cmd.op)
                  dat_pkg::OP_SEND: begin
                     rsp_payload_in.seq_out = next_out_seq_ff;
                     if (fill_ff == dat_pkg::FillWidth'(dat_pkg::PendingDepth)) begin
                        rsp_payload_in.kind = dat_pkg::KIND_FULL;
                     end else begin
                        rsp_payload_in.kind = dat_pkg::KIND_SENT;
                        ram_wr_en           = 1'b1;
                        fill_in             = fill_ff + 1'b1;
                        next_out_seq_in     = next_out_seq_ff + 1'b1;
                     end
                  end
                  dat_pkg::OP_RECEIVE: begin
                     rsp_payload_in.seq_out = cmd.seq_number;
                     if (cmd.seq_number >= next_expected_seq_ff) begin
                        rsp_payload_in.kind = dat_pkg::KIND_ACCEPTED;
                        if (ack_pending_count_ff == '0) begin
                           ack_first_in = cmd.seq_number;
                        end
                        ack_pending_count_in        = count_new;
                        next_expected_seq_in        = cmd.seq_number + 1'b1;
                        rsp_payload_in.acks_pending = 1'b1;
                     end else begin
                        rsp_payload_in.kind = dat_pkg::KIND_REJECTED;
                     end
                  end
                  dat_pkg::OP_BUILD_ACK: begin
                     rsp_payload_in.kind         = dat_pkg::KIND_ACK_REC;
                     rsp_payload_in.seq_out      = (ack_pending_count_ff != '0) ?
                                                   ack_first_ff : '0;
                     rsp_payload_in.count_out    = ack_pending_count_ff;
                     rsp_payload_in.acks_pending = 1'b0;
                     ack_pending_count_in        = '0;
                     ack_first_in                = '0;
                  end
                  dat_pkg::OP_PROCESS_ACK: begin
                     // Walk only for a non-empty range; done otherwise
                     if (cmd.ack_count != '0) begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        walk_ack_in  = 1'b1;
                        nxt_in       = cmd.seq_number;
                        end_in       = cmd.seq_number + dat_pkg::SeqWidth'(cmd.ack_count);
                        n_in         = '0;
                        state_in     = dat_pkg::ST_READ;
                     end
                  end
                  dat_pkg::OP_TIMEOUT: begin
                     if (cmd.now >= ack_timeout) begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        walk_ack_in  = 1'b0;
                        limit_in     = cmd.now - ack_timeout;
                        n_in         = '0;
                        state_in     = dat_pkg::ST_READ;
                     end
                  end
                  dat_pkg::OP_CLEAR: begin
                     next_out_seq_in             = '0;
                     next_expected_seq_in        = '0;
                     ack_first_in                = '0;
                     ack_pending_count_in        = '0;
                     head_in                     = '0;
                     fill_in                     = '0;
                     rsp_payload_in.acks_pending = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         dat_pkg::ST_READ: begin
            if (walk_go) begin
               ram_rd_en = 1'b1;
               state_in  = dat_pkg::ST_EVAL;
            end else begin
               state_in = dat_pkg::ST_FINISH;
            end
         end
         dat_pkg::ST_EVAL: begin
            if (ev_stop) begin
               state_in = dat_pkg::ST_FINISH;
            end else if (ev_emit && (!hold_valid_ff || out_free)) begin
               // Release the held result, not the last of this item
               if (hold_valid_ff) begin
                  rsp_valid_in           = 1'b1;
                  rsp_payload_in.kind    = hold_kind_ff;
                  rsp_payload_in.seq_out = hold_seq_ff;
                  rsp_payload_in.last    = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_kind_in  = ev_kind;
               hold_seq_in   = entry_seq;
               n_in          = n_ff + 1'b1;
               head_in       = head_next;
               fill_in       = fill_ff - 1'b1;
               if (walk_ack_ff && (ev_kind == dat_pkg::KIND_SUCCESS)) begin
                  nxt_in = entry_seq + 1'b1;
               end
               state_in = dat_pkg::ST_READ;
            end
         end
         dat_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_payload_in.kind    = hold_kind_ff;
                  rsp_payload_in.seq_out = hold_seq_ff;
               end else begin
                  rsp_payload_in.kind    = dat_pkg::KIND_DONE;
                  rsp_payload_in.seq_out = '0;
               end
               hold_valid_in = 1'b0;
               state_in      = dat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dat_pkg::ST_IDLE;
         end
      endcase

      // Keep a waiting result untouched
      if (rsp_valid_ff && rsp_stall) begin
         rsp_payload_in = rsp_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= dat_pkg::ST_IDLE;
         next_out_seq_ff      <= '0;
         next_expected_seq_ff <= '0;
         ack_first_ff         <= '0;
         ack_pending_count_ff <= '0;
         head_ff              <= '0;
         fill_ff              <= '0;
         walk_ack_ff          <= 1'b0;
         n_ff                 <= '0;
         hold_valid_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         next_out_seq_ff      <= next_out_seq_in;
         next_expected_seq_ff <= next_expected_seq_in;
         ack_first_ff         <= ack_first_in;
         ack_pending_count_ff <= ack_pending_count_in;
         head_ff              <= head_in;
         fill_ff              <= fill_in;
         walk_ack_ff          <= walk_ack_in;
         n_ff                 <= n_in;
         hold_valid_ff        <= hold_valid_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff         <= nxt_in;
      end_ff         <= end_in;
      limit_ff       <= limit_in;
      hold_kind_ff   <= hold_kind_in;
      hold_seq_ff    <= hold_seq_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hdl/delivery_ack_tracker.sv
`timescale 1ns / 1ps
// ============================================================================
// delivery_ack_tracker
// Sequence-number bookkeeping for reliable delivery with acknowledgements.
// ============================================================================
// Each input item carries a function code (send, receive, build ack, process
// ack, timeout check, clear) and gives one or more result items; the last
// result of an item has last set. A front stage decodes items into a
// two-entry command queue, so items are taken while the back stage works.
// Send, receive, build ack, clear and unused codes are executed by the back
// stage at one item per cycle while results drain, with the result registered
// as the back stage takes the item from the command queue. Process ack and
// timeout check walk the pending queue, one 64-entry RAM with a registered
// read, popping at most 64 entries per item. Timestamps are in ticks;
// ack_timeout (byte address 0) resets to 1000 and should be written
// only while no item is in flight.
// ============================================================================
module delivery_ack_tracker (
   input  logic                             clock,
   input  logic                             reset,
   // Input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dat_pkg::req_type                 req_payload,
   // Result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dat_pkg::rsp_type                 rsp_payload,
   // Register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dat_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [dat_pkg::CsrDataWidth-1:0] pwdata,
   output logic [dat_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready
);

   logic [dat_pkg::SeqWidth-1:0] ack_timeout_ff, ack_timeout_in;
   logic                         csr_hit;
   logic                         csr_write;
   dat_pkg::cmd_chan_type        cmd_chan;
   logic                         cmd_take;

   // Register port: no wait states; only the top address bit selects the register
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[dat_pkg::CsrAddrWidth-1] == dat_pkg::CsrIndexAckTimeout);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? ack_timeout_ff : '0;

   always_comb begin
      ack_timeout_in = ack_timeout_ff;
      if (csr_write) begin
         ack_timeout_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= dat_pkg::AckTimeoutReset;
      end else begin
         ack_timeout_ff <= ack_timeout_in;
      end
   end

   // Front: accept and decode items, hold them in the command queue
   dat_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_chan    (cmd_chan),
      .cmd_take    (cmd_take)
   );

   // Back: execute commands, walk the pending queue, drive results
   dat_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_chan    (cmd_chan),
      .cmd_take    (cmd_take),
      .ack_timeout (ack_timeout_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/delivery_ack_tracker_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// delivery_ack_tracker_tb
// Self-checking bench for the delivery acknowledgement tracker.
// ============================================================================
// A ledger object mirrors the tracker's bookkeeping: the outgoing and expected
// sequence counters, the acknowledgement record and the pending delivery queue
// with send times. Every item accepted on the request side is played through
// the ledger, and each result item it produces is queued. Results leaving the
// tracker are compared field by field against the oldest queued one.
// Stimulus runs a directed pass over the corner cases (empty record, wrapped
// ranges, full queue, 64-entry walks), then random items biased toward
// well-formed send/receive/ack traffic, under several ack_timeout settings.
// Both handshake sides idle at random, and the result side holds off once for
// a long stretch to back the tracker up.
// ============================================================================
module delivery_ack_tracker_tb;

   localparam int HOLD_CYCLES = 400;    // long result-side hold-off
   localparam int STALL_LIMIT = 4000;   // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES = 150;  // longer than one 64-entry walk

   // Spare function codes: the tracker must answer them with a bare done
   localparam logic [dat_pkg::FuncWidth-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [dat_pkg::FuncWidth-1:0] FUNC_SPARE_7 = 3'd7;

   localparam logic [dat_pkg::CsrAddrWidth-1:0] TIMEOUT_ADDR =
      {dat_pkg::CsrIndexAckTimeout, 2'b00};

   // -------------------------------------------------------------------------
   // Ledger: predicts result items and holds the ones still owed
   // -------------------------------------------------------------------------
   class delivery_ledger;
      bit [31:0]        timeout_ticks;
      bit [31:0]        out_seq;
      bit [31:0]        expect_seq;
      bit [31:0]        first_rec;
      bit [15:0]        rec_count;
      bit [31:0]        q_seq [dat_pkg::PendingDepth];
      bit [31:0]        q_time [dat_pkg::PendingDepth];
      int unsigned      head;
      int unsigned      fill;
      dat_pkg::rsp_type awaited[$];
      int               mismatches;

      function new();
         timeout_ticks = dat_pkg::AckTimeoutReset;
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         out_seq = '0;
         expect_seq = '0;
         first_rec = '0;
         rec_count = '0;
         head = 0;
         fill = 0;
      endfunction

      function dat_pkg::rsp_type make_rsp(dat_pkg::kind_type k, bit [31:0] seq,
                                          bit [15:0] count);
         dat_pkg::rsp_type r;
         r.kind = k;
         r.seq_out = seq;
         r.count_out = count;
         r.acks_pending = 1'b0;
         r.last = 1'b0;
         return r;
      endfunction

      function void drop_head();
         head = (head + 1) % dat_pkg::PendingDepth;
         fill--;
      endfunction

      // Play one accepted item through the ledger and queue its results
      function void note_item(dat_pkg::req_type item);
         dat_pkg::rsp_type batch[$];
         dat_pkg::rsp_type r;
         bit [31:0]        nxt;
         bit [31:0]        stop;
         bit [31:0]        lim;
         bit [31:0]        s;
         case (item.func)
            dat_pkg::FUNC_SEND: begin
               if (fill >= dat_pkg::PendingDepth) begin
                  batch = {batch, make_rsp(dat_pkg::KIND_FULL, out_seq, '0)};
               end else begin
                  q_seq[(head + fill) % dat_pkg::PendingDepth] = out_seq;
                  q_time[(head + fill) % dat_pkg::PendingDepth] = item.now;
                  fill++;
                  batch = {batch, make_rsp(dat_pkg::KIND_SENT, out_seq, '0)};
                  out_seq = out_seq + 1;
               end
            end
            dat_pkg::FUNC_RECEIVE: begin
               if (item.seq_number >= expect_seq) begin
                  if (rec_count == 0) first_rec = item.seq_number;
                  if (rec_count != dat_pkg::AckCountMax) rec_count++;
                  expect_seq = item.seq_number + 1;
                  batch = {batch, make_rsp(dat_pkg::KIND_ACCEPTED, item.seq_number, '0)};
               end else begin
                  batch = {batch, make_rsp(dat_pkg::KIND_REJECTED, item.seq_number, '0)};
               end
            end
            dat_pkg::FUNC_BUILD_ACK: begin
               batch = {batch, make_rsp(dat_pkg::KIND_ACK_REC,
                                        (rec_count != 0) ? first_rec : '0, rec_count)};
               rec_count = '0;
               first_rec = '0;
            end
            dat_pkg::FUNC_PROCESS_ACK: begin
               if (item.ack_count != 0) begin
                  nxt = item.seq_number;
                  stop = item.seq_number + 32'(item.ack_count);   // wraps mod 2^32
                  while (nxt < stop && fill > 0 && batch.size() < dat_pkg::ResultLimit) begin
                     s = q_seq[head];
                     if (s == nxt) begin
                        batch = {batch, make_rsp(dat_pkg::KIND_SUCCESS, s, '0)};
                        drop_head();
                        nxt = nxt + 1;
                     end else if (s < nxt) begin
                        batch = {batch, make_rsp(dat_pkg::KIND_FAILURE, s, '0)};
                        drop_head();
                     end else begin
                        nxt = (s < stop) ? s : stop;
                     end
                  end
               end
            end
            dat_pkg::FUNC_TIMEOUT: begin
               // nothing can expire until the window has opened
               if (item.now >= timeout_ticks) begin
                  lim = item.now - timeout_ticks;
                  while (fill > 0 && batch.size() < dat_pkg::ResultLimit
                         && q_time[head] < lim) begin
                     batch = {batch, make_rsp(dat_pkg::KIND_FAILURE, q_seq[head], '0)};
                     drop_head();
                  end
               end
            end
            dat_pkg::FUNC_CLEAR: clear_state();
            default: ;
         endcase
         if (batch.size() == 0) batch = {batch, make_rsp(dat_pkg::KIND_DONE, '0, '0)};
         // acks_pending reflects the state after the whole item
         foreach (batch[i]) begin
            r = batch[i];
            r.acks_pending = (rec_count != 0);
            r.last = (i == batch.size() - 1);
            awaited = {awaited, r};
         end
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
      endfunction

      // Compare one result item with the oldest one owed
      function void check_result(dat_pkg::rsp_type got);
         dat_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t ns: result with none expected, got kind %0d seq %h count %h",
                     $time, got.kind, got.seq_out, got.count_out);
            return;
         end
         want = awaited[0];
         awaited.delete(0);
         if (got.kind !== want.kind) flag("kind", 32'(want.kind), 32'(got.kind));
         if (got.seq_out !== want.seq_out) flag("seq_out", want.seq_out, got.seq_out);
         if (got.count_out !== want.count_out)
            flag("count_out", 32'(want.count_out), 32'(got.count_out));
         if (got.acks_pending !== want.acks_pending)
            flag("acks_pending", 32'(want.acks_pending), 32'(got.acks_pending));
         if (got.last !== want.last) flag("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the tracker
   // -------------------------------------------------------------------------
   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   dat_pkg::req_type                 req_payload;
   logic                             rsp_valid;
   logic                             rsp_stall;
   dat_pkg::rsp_type                 rsp_payload;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [dat_pkg::CsrAddrWidth-1:0] paddr;
   logic [dat_pkg::CsrDataWidth-1:0] pwdata;
   logic [dat_pkg::CsrDataWidth-1:0] prdata;
   logic                             pready;

   delivery_ledger ledger;
   bit [31:0]      tick;          // running send time for well-formed traffic
   bit             quiet;         // suppress idling on both sides
   bit             hold_request;  // ask the result side for one long hold-off
   int             idle_cycles;

   delivery_ack_tracker uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic dat_pkg::req_type mk(input logic [dat_pkg::FuncWidth-1:0] func,
                                           input logic [31:0] seq,
                                           input logic [15:0] count,
                                           input logic [31:0] now);
      dat_pkg::req_type it;
      it.func = func;
      it.seq_number = seq;
      it.ack_count = count;
      it.now = now;
      return it;
   endfunction

   // Build one random item from the ledger's current view so that most of
   // them land on live sequence numbers and open timeout windows.
   function automatic dat_pkg::req_type random_item();
      dat_pkg::req_type it;
      int               pick;
      bit [31:0]        base;
      bit [31:0]        front;
      longint           reach;
      it = mk(dat_pkg::FUNC_SEND, $urandom, 16'($urandom), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 26) begin
         tick = tick + $urandom_range(0, 60);
         it.now = tick;
      end else if (pick < 46) begin
         it.func = dat_pkg::FUNC_RECEIVE;
         case ($urandom_range(0, 5))
            0: it.seq_number = ledger.expect_seq - $urandom_range(1, 8);   // stale
            1: ;                                                           // anywhere
            default: it.seq_number = ledger.expect_seq + $urandom_range(0, 3);
         endcase
      end else if (pick < 55) begin
         it.func = dat_pkg::FUNC_BUILD_ACK;
      end else if (pick < 74) begin
         it.func = dat_pkg::FUNC_PROCESS_ACK;
         base = (ledger.fill > 0) ? ledger.q_seq[ledger.head] : ledger.out_seq;
         case ($urandom_range(0, 7))
            0: it.ack_count = '0;
            1: begin
               it.seq_number = base - $urandom_range(1, 4);
               it.ack_count = 16'($urandom_range(1, 8));
            end
            default: begin
               it.seq_number = base + $urandom_range(0, 3);
               it.ack_count = 16'($urandom_range(1, ledger.fill + 4));
            end
         endcase
      end else if (pick < 86) begin
         it.func = dat_pkg::FUNC_TIMEOUT;
         front = (ledger.fill > 0) ? ledger.q_time[ledger.head] : tick;
         if ($urandom_range(0, 4) == 0) begin
            // before the window opens
            it.now = (ledger.timeout_ticks == 0) ? 32'd0
                                                 : $urandom_range(0, ledger.timeout_ticks - 1);
         end else begin
            // straddle the expiry point of the oldest entry
            reach = longint'(front) + longint'(ledger.timeout_ticks)
                    + longint'($urandom_range(0, 600)) - 100;
            if (reach < 0) reach = 0;
            if (reach > longint'(32'hFFFF_FFFF)) reach = longint'(32'hFFFF_FFFF);
            it.now = reach[31:0];
         end
      end else if (pick < 89) begin
         it.func = dat_pkg::FUNC_CLEAR;
      end else if (pick < 93) begin
         it.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      end else begin
         it.func = 3'($urandom_range(0, 7));   // noise: everything random
      end
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Request side: called at a falling edge, returns at a falling edge
   // -------------------------------------------------------------------------
   task automatic offer(input dat_pkg::req_type item);
      int gap;
      gap = quiet ? 0 : gap_length();
      repeat (gap) @(negedge clock);
      req_payload = item;
      req_valid = 1'b1;
      // hold the item until the tracker takes it
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_item(item);
      @(negedge clock);
      // drop valid; a following offer in this step raises it again
      req_valid = 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) offer(random_item());
   endtask

   // Wait until every owed result is back; every item yields one, so the
   // tracker is idle then, give it a few cycles anyway
   task automatic drain();
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register port
   // -------------------------------------------------------------------------
   task automatic csr_check(input logic [31:0] want);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = TIMEOUT_ADDR;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         ledger.mismatches++;
         $display("%0t ns: ack_timeout read expected %h, got %h", $time, want, prdata);
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_timeout(input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = TIMEOUT_ADDR;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      ledger.timeout_ticks = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      csr_check(value);
   endtask

   // -------------------------------------------------------------------------
   // Directed cases
   // -------------------------------------------------------------------------
   task automatic run_directed();
      // empty record, zero-length ack, ack on an empty queue, closed window
      offer(mk(dat_pkg::FUNC_BUILD_ACK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      offer(mk(dat_pkg::FUNC_PROCESS_ACK, 32'd0, 16'd0, 32'd0));
      offer(mk(dat_pkg::FUNC_PROCESS_ACK, 32'd0, 16'd5, 32'd0));
      offer(mk(dat_pkg::FUNC_TIMEOUT, 32'd0, 16'd0, 32'd999));
      // spare codes answer with done and change nothing
      offer(mk(FUNC_SPARE_6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      offer(mk(FUNC_SPARE_7, 32'd0, 16'd0, 32'd0));
      // accept, reject a stale number, wrap the expected counter, rebuild
      offer(mk(dat_pkg::FUNC_RECEIVE, 32'd5, 16'd0, 32'd0));
      offer(mk(dat_pkg::FUNC_RECEIVE, 32'd3, 16'd0, 32'd0));
      offer(mk(dat_pkg::FUNC_RECEIVE, 32'hFFFF_FFFF, 16'd0, 32'd0));
      offer(mk(dat_pkg::FUNC_RECEIVE, 32'd0, 16'd0, 32'd0));
      offer(mk(dat_pkg::FUNC_BUILD_ACK, 32'd0, 16'd0, 32'd0));
      // queue four deliveries
      offer(mk(dat_pkg::FUNC_SEND, 32'd0, 16'd0, 32'd100));
      offer(mk(dat_pkg::FUNC_SEND, 32'd0, 16'd0, 32'd200));
      offer(mk(dat_pkg::FUNC_SEND, 32'd0, 16'd0, 32'd300));
      offer(mk(dat_pkg::FUNC_SEND, 32'd0, 16'd0, 32'd400));
      // skip the oldest: one failure then one success
      offer(mk(dat_pkg::FUNC_PROCESS_ACK, 32'd1, 16'd1, 32'd0));
      // range end wraps below its start: nothing walks
      offer(mk(dat_pkg::FUNC_PROCESS_ACK, 32'hFFFF_FFF0, 16'h0020, 32'd0));
      // expire exactly one entry
      offer(mk(dat_pkg::FUNC_TIMEOUT, 32'd0, 16'd0, 32'd1301));
      offer(mk(dat_pkg::FUNC_PROCESS_ACK, 32'd5, 16'hFFFF, 32'd0));
      // latest possible send time never expires
      offer(mk(dat_pkg::FUNC_SEND, 32'd0, 16'd0, 32'hFFFF_FFFF));
      offer(mk(dat_pkg::FUNC_TIMEOUT, 32'd0, 16'd0, 32'hFFFF_FFFF));
      offer(mk(dat_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      offer(mk(dat_pkg::FUNC_SEND, 32'd0, 16'd0, 32'd0));
      offer(mk(dat_pkg::FUNC_CLEAR, 32'd0, 16'd0, 32'd0));
   endtask

   // Fill the queue back to back, hit full, then empty it with one
   // full-length walk of each kind: acknowledgement and expiry
   task automatic run_full_queue();
      int i;
      quiet = 1'b1;
      for (i = 0; i <= dat_pkg::PendingDepth; i++) begin
         tick = tick + 7;
         offer(mk(dat_pkg::FUNC_SEND, $urandom, 16'($urandom), tick));
      end
      offer(mk(dat_pkg::FUNC_PROCESS_ACK, ledger.q_seq[ledger.head],
               16'(dat_pkg::PendingDepth), $urandom));
      for (i = 0; i < dat_pkg::PendingDepth; i++) begin
         tick = tick + 7;
         offer(mk(dat_pkg::FUNC_SEND, $urandom, 16'($urandom), tick));
      end
      offer(mk(dat_pkg::FUNC_TIMEOUT, $urandom, 16'($urandom), 32'hFFFF_FFFF));
      quiet = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Result side: stall driven at the falling edge, results taken at the rising
   // -------------------------------------------------------------------------
   initial begin
      int run;
      run = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            // back the tracker up until it stalls its input
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_request = 1'b0;
            run = 0;
         end else if (quiet) begin
            rsp_stall = 1'b0;
            run = 0;
         end else if (run > 0) begin
            run--;
         end else if (rsp_stall) begin
            // open up, sometimes for a long stretch
            rsp_stall = 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
         end else begin
            run = gap_length();
            if (run > 0) begin
               rsp_stall = 1'b1;
               run--;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check_result(rsp_payload);
   end

   // Watchdog: give up when no item moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      ledger = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tick = '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset value of the window, then corner cases under it
      csr_check(dat_pkg::AckTimeoutReset);
      run_directed();
      run_full_queue();
      hold_request = 1'b1;
      run_random(60);
      drain();

      // zero window: everything older than now expires
      set_timeout(32'd0);
      run_random(55);
      drain();

      // widest window: a walk opens only at the last tick and expires nothing
      set_timeout(32'hFFFF_FFFF);
      run_random(50);
      drain();

      set_timeout(32'd200);
      run_random(55);
      drain();

      set_timeout($urandom_range(1, 5000));
      run_random(55);
      drain();

      // let any stray result show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
